### hdl/mtrm_pkg.sv
// Package for the multi-timescale rate meter.
// Holds sizes, codes and the request/result structs; no dependencies.
package mtrm_pkg;

  localparam int LEVELS = 8;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PW     = 61;           // period and divisor width
  localparam int MW     = 32;           // counter magnitude width
  localparam int PRODW  = PW + MW;      // c*P magnitude width
  localparam int NUMW   = PRODW + 1;    // signed numerator width
  localparam int TW     = 48;
  localparam logic [PW-1:0] PERIOD_CAP = {1'b1, {(PW-1){1'b0}}};

  localparam logic [1:0] MODE_RECORD  = 2'd0;
  localparam logic [1:0] MODE_CLAMP   = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [1:0] REG_BASE_PERIOD   = 2'd0;
  localparam logic [1:0] REG_PERIOD_FACTOR = 2'd1;
  localparam logic [1:0] REG_INITIAL_VALUE = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [TW-1:0]      timestamp;
    logic signed [31:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         level;
    logic signed [31:0] rate;
    logic               last;
  } out_item_t;

endpackage

### hdl/multi_timescale_rate_meter_core.sv
// Multi-timescale rate meter top level: counters, serial multiplier and divider.
// Depends on mtrm_pkg.
//
// One request at a time. A record request (mode 0) runs each of the eight levels
// through a bit-serial shift-add multiplier and a restoring divider that retires
// one quotient bit per cycle, with setup in the load and add states and write-back
// in the emit state. Clamp, restart and unused modes emit the current counter value
// of each level without computing. Results leave through an output register,
// level 0 first; back-pressure on the output stalls the level loop.
module multi_timescale_rate_meter_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mtrm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mtrm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_MUL  = 6'b000100,
    S_ADD  = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state;

  logic [31:0] base_period;
  logic [4:0]  period_factor;
  logic [31:0] initial_value;

  logic [31:0] counters [mtrm_pkg::LEVELS];
  logic [mtrm_pkg::TW-1:0] last_time;
  logic        time_valid;

  logic [1:0]  mode;
  logic [31:0] amount;
  logic [mtrm_pkg::TW-1:0] elapsed;
  logic [mtrm_pkg::PW-1:0] period;
  logic [mtrm_pkg::PW-1:0] den;
  logic [mtrm_pkg::LVL_W-1:0] lvl;

  logic        cneg;
  logic [mtrm_pkg::PW:0] hi;
  logic [31:0] lo;
  logic [4:0]  mul_cnt;

  logic [mtrm_pkg::PRODW-1:0] dvd;
  logic [mtrm_pkg::PW-1:0]    rem;
  logic [31:0] quo;
  logic        ovf;
  logic        qneg;
  logic [6:0]  div_cnt;

  logic        accept;
  logic        slot_free;
  logic        last_lvl;
  logic [mtrm_pkg::PW:0] mul_acc;
  logic [mtrm_pkg::NUMW-1:0] num;
  logic [mtrm_pkg::NUMW-1:0] num_abs;
  logic [mtrm_pkg::PW:0] rem_sh;
  logic        rem_ge;
  logic [31:0] result;
  logic        q_big;
  logic [mtrm_pkg::PW+4:0] p_mul;
  logic [mtrm_pkg::PW-1:0] period_next;
  logic [31:0] cur;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign last_lvl  = (lvl == mtrm_pkg::LVL_W'(mtrm_pkg::LEVELS - 1));
  assign cur       = counters[lvl];

  assign mul_acc = hi + (lo[0] ? {1'b0, period} : '0);

  always_comb begin
    logic [mtrm_pkg::NUMW-1:0] prod_s;
    prod_s  = {1'b0, hi[mtrm_pkg::PW-1:0], lo};
    if (cneg) prod_s = -prod_s;
    num     = prod_s + {{(mtrm_pkg::NUMW-32){amount[31]}}, amount};
    num_abs = num[mtrm_pkg::NUMW-1] ? -num : num;
  end

  assign rem_sh = {rem, dvd[mtrm_pkg::PRODW-1]};
  assign rem_ge = rem_sh >= {1'b0, den};

  // saturate the quotient to the signed 32-bit range
  assign q_big = ovf || quo[31];
  always_comb begin
    if (qneg) result = q_big ? 32'h8000_0000 : -quo;
    else      result = q_big ? 32'h7FFF_FFFF : quo;
  end

  assign p_mul = period * period_factor;
  always_comb begin
    if (period_factor == '0)
      period_next = mtrm_pkg::PW'(1);
    else if (p_mul > {5'd0, mtrm_pkg::PERIOD_CAP})
      period_next = mtrm_pkg::PERIOD_CAP;
    else
      period_next = p_mul[mtrm_pkg::PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_period   <= 32'd1000000;
      period_factor <= 5'd2;
      initial_value <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtrm_pkg::REG_BASE_PERIOD:   base_period   <= cfg_data;
        mtrm_pkg::REG_PERIOD_FACTOR: period_factor <= cfg_data[4:0];
        mtrm_pkg::REG_INITIAL_VALUE: initial_value <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      time_valid <= 1'b0;
      last_time  <= '0;
      out_valid  <= 1'b0;
      lvl        <= '0;
      for (int i = 0; i < mtrm_pkg::LEVELS; i++) counters[i] <= '0;
    end else begin
      // the emit state handles its own output handshake
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mode   <= in_data.mode;
            amount <= in_data.amount;
            lvl    <= '0;
            period <= (base_period == '0) ? mtrm_pkg::PW'(1) : mtrm_pkg::PW'(base_period);
            if (in_data.mode == mtrm_pkg::MODE_RECORD) begin
              elapsed    <= (time_valid && in_data.timestamp >= last_time)
                            ? in_data.timestamp - last_time : '0;
              last_time  <= in_data.timestamp;
              time_valid <= 1'b1;
              state      <= S_LOAD;
            end else begin
              if (in_data.mode == mtrm_pkg::MODE_CLAMP) begin
                for (int i = 0; i < mtrm_pkg::LEVELS; i++)
                  if (counters[i][31]) counters[i] <= '0;
              end else if (in_data.mode == mtrm_pkg::MODE_RESTART) begin
                for (int i = 0; i < mtrm_pkg::LEVELS; i++) counters[i] <= initial_value;
                last_time  <= '0;
                time_valid <= 1'b0;
              end
              state <= S_EMIT;
            end
          end
        end
        S_LOAD: begin
          cneg    <= cur[31];
          hi      <= '0;
          lo      <= cur[31] ? -cur : cur;
          den     <= period + mtrm_pkg::PW'(elapsed);
          mul_cnt <= '0;
          state   <= S_MUL;
        end
        S_MUL: begin
          // add the period on a set bit, then shift the product right
          hi      <= mul_acc >> 1;
          lo      <= {mul_acc[0], lo[31:1]};
          mul_cnt <= mul_cnt + 5'd1;
          if (mul_cnt == 5'd31) state <= S_ADD;
        end
        S_ADD: begin
          qneg    <= num[mtrm_pkg::NUMW-1];
          dvd     <= num_abs[mtrm_pkg::PRODW-1:0];
          rem     <= '0;
          quo     <= '0;
          ovf     <= 1'b0;
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem     <= rem_ge ? mtrm_pkg::PW'(rem_sh - {1'b0, den})
                            : rem_sh[mtrm_pkg::PW-1:0];
          dvd     <= dvd << 1;
          quo     <= {quo[30:0], rem_ge};
          ovf     <= ovf | quo[31];
          div_cnt <= div_cnt + 7'd1;
          if (div_cnt == 7'(mtrm_pkg::PRODW - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid      <= 1'b1;
            out_data.level <= 3'(lvl);
            out_data.last  <= last_lvl;
            if (mode == mtrm_pkg::MODE_RECORD) begin
              counters[lvl] <= result;
              out_data.rate <= result;
            end else begin
              out_data.rate <= cur;
            end
            period <= period_next;
            if (last_lvl) begin
              state <= S_IDLE;
            end else begin
              lvl   <= lvl + mtrm_pkg::LVL_W'(1);
              state <= (mode == mtrm_pkg::MODE_RECORD) ? S_LOAD : S_EMIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready) else $error("request taken while busy");

  a_last_on_top_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last) |-> out_data.level == 3'(mtrm_pkg::LEVELS - 1))
    else $error("last flag on wrong level");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> den != '0) else $error("zero divisor");

  a_record_sets_time: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.mode == mtrm_pkg::MODE_RECORD) |=> time_valid)
    else $error("record did not mark time");

endmodule
